// File: rtl/core/quadratic_root_solver_unit_defines.svh
// Assertion macros used by the solver top module
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define QRS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qrs assertion failed");
`define QRS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qrs assertion failed");
`else
`define QRS_ASSERT_IMP(lbl, ante, cons)
`define QRS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
	typedef enum logic [1:0] {
		ST_ONE   = 2'd0,
		ST_TWO   = 2'd1,
		ST_NONE  = 2'd2,
		ST_DEGEN = 2'd3
	} status_t;

	// square root: radicand, root and partial remainder widths
	localparam int RAD_W      = 62;
	localparam int ROOT_W     = 31;
	localparam int REM_W      = ROOT_W + 2;
	localparam int SQ_STAGES  = RAD_W / 2;
	// divider: dividend/quotient and divisor widths
	localparam int NUM_W      = 36;
	localparam int DEN_W      = 17;
	localparam int DIV_STAGES = NUM_W;

	typedef struct packed {
		status_t            status;
		logic               lin;
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] c;
	} sq_side_t;

	typedef struct packed {
		status_t status;
		logic    neg1;
		logic    neg2;
	} div_side_t;
endpackage
`default_nettype wire

// File: rtl/core/quadratic_root_solver_unit.sv
// Requests pass s1, s2, s3, the square root, s4, the divider and the output register.
// Throughput: one request per cycle while not stalled; the 31-stage square root
// and the 36-stage divider each retire one bit per stage and hold one item per stage.
// A stall stops the whole pipeline only while its last stage holds an item.
// Reset (arst_n low, asynchronous) clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_root_solver_unit_defines.svh"
module quadratic_root_solver_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] coef_quad,
	input  wire logic signed [15:0] coef_lin,
	input  wire logic signed [15:0] coef_const,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic signed [31:0]      root_first,
	output logic signed [31:0]      root_second,
	output logic                    saturated
);
	localparam int NW = qrs_pkg::NUM_W;

	logic en, out_free;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [15:0] a_s1, b_s1, c_s1;
	logic signed [15:0] a_s2, b_s2, c_s2;
	logic signed [31:0] bb_s2, ac_s2;
	qrs_pkg::sq_side_t side_s3;
	logic [qrs_pkg::RAD_W-1:0] rad_s3;
	logic sq_vld;
	logic [qrs_pkg::ROOT_W-1:0] sq_root;
	qrs_pkg::sq_side_t sq_side;
	logic [NW-1:0] x1_s4, x2_s4;
	logic [qrs_pkg::DEN_W-1:0] d_s4;
	qrs_pkg::div_side_t dside_s4;
	logic dv_vld;
	logic [NW-1:0] q1, q2;
	qrs_pkg::div_side_t dv_side;

	logic out_valid_q, saturated_q;
	qrs_pkg::status_t status_q;
	logic [31:0] root_first_q, root_second_q;

	// advance unless the last stage is full and the output cannot take it
	assign out_free = !out_valid_q || out_ready;
	assign en       = out_free || !dv_vld;
	assign in_ready = en;

	// valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= sq_vld;
		end
	end

	// capture coefficients, then form the products
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1  <= coef_quad;
			b_s1  <= coef_lin;
			c_s1  <= coef_const;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			c_s2  <= c_s1;
			bb_s2 <= b_s1 * b_s1;
			ac_s2 <= a_s1 * c_s1;
		end
	end

	// discriminant and case selection
	logic signed [33:0] disc;
	qrs_pkg::sq_side_t side_nx;
	logic [qrs_pkg::RAD_W-1:0] rad_nx;

	always_comb begin
		disc           = {{2{bb_s2[31]}}, bb_s2} - {ac_s2, 2'b00};
		side_nx.a      = a_s2;
		side_nx.b      = b_s2;
		side_nx.c      = c_s2;
		side_nx.lin    = 1'b0;
		side_nx.status = qrs_pkg::ST_NONE;
		rad_nx         = '0;
		if (a_s2 == 16'sd0) begin
			if (b_s2 == 16'sd0) begin
				side_nx.status = qrs_pkg::ST_DEGEN;
			end else begin
				side_nx.status = qrs_pkg::ST_ONE;
				side_nx.lin    = 1'b1;
			end
		end else if (disc > 34'sd0) begin
			side_nx.status = qrs_pkg::ST_TWO;
			rad_nx         = {1'b0, disc[32:0], 28'd0};
		end else if (disc == 34'sd0) begin
			side_nx.status = qrs_pkg::ST_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_nx;
			rad_s3  <= rad_nx;
		end
	end

	qrs_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s3),
		.in_rad   (rad_s3),
		.in_side  (side_s3),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side)
	);

	// numerators, signs and magnitudes for the dividers
	logic signed [NW-1:0] b36, c36, s36, base, num1, num2;
	logic signed [15:0] den;
	logic [15:0] ud;
	logic [NW-1:0] un1, un2;
	qrs_pkg::div_side_t dside_nx;

	always_comb begin
		b36  = NW'(sq_side.b);
		c36  = NW'(sq_side.c);
		s36  = NW'({1'b0, sq_root});
		base = (-b36) <<< 14;
		num2 = '0;
		den  = sq_side.a;
		if (sq_side.lin) begin
			num1 = (-c36) <<< 16;
			den  = sq_side.b;
		end else if (sq_side.status == qrs_pkg::ST_TWO) begin
			num1 = (base + s36) <<< 1;
			num2 = (base - s36) <<< 1;
		end else begin
			num1 = (-b36) <<< 15;
		end
		ud              = den[15] ? 16'(-den) : 16'(den);
		un1             = num1[NW-1] ? NW'(-num1) : NW'(num1);
		un2             = num2[NW-1] ? NW'(-num2) : NW'(num2);
		dside_nx.status = sq_side.status;
		dside_nx.neg1   = num1[NW-1] ^ den[15];
		dside_nx.neg2   = num2[NW-1] ^ den[15];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s4    <= NW'({un1[NW-2:0], 1'b0}) + NW'(ud);
			x2_s4    <= NW'({un2[NW-2:0], 1'b0}) + NW'(ud);
			d_s4     <= {ud, 1'b0};
			dside_s4 <= dside_nx;
		end
	end

	qrs_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (v_s4),
		.in_x1    (x1_s4),
		.in_x2    (x2_s4),
		.in_d     (d_s4),
		.in_side  (dside_s4),
		.out_vld  (dv_vld),
		.out_q1   (q1),
		.out_q2   (q2),
		.out_side (dv_side)
	);

	// sign and clip one quotient; returns {clipped, value}
	function automatic logic [32:0] sat_root(input logic [NW-1:0] q, input logic neg);
		logic [32:0] r;
		r = '0;
		if (q == '0) begin
			r = '0;
		end else if (neg) begin
			if (q > NW'(33'h1_0000_0000 >> 1)) begin
				r = {1'b1, 32'h8000_0000};
			end else begin
				r = {1'b0, 32'(-q[31:0])};
			end
		end else begin
			if (q > NW'(32'h7FFF_FFFF)) begin
				r = {1'b1, 32'h7FFF_FFFF};
			end else begin
				r = {1'b0, q[31:0]};
			end
		end
		return r;
	endfunction

	logic [32:0] r1c, r2c;
	logic [31:0] rf_nx, rs_nx;
	logic sat_nx;

	always_comb begin
		r1c    = sat_root(q1, dv_side.neg1);
		r2c    = sat_root(q2, dv_side.neg2);
		rf_nx  = '0;
		rs_nx  = '0;
		sat_nx = 1'b0;
		case (dv_side.status)
			qrs_pkg::ST_ONE: begin
				rf_nx  = r1c[31:0];
				sat_nx = r1c[32];
			end
			qrs_pkg::ST_TWO: begin
				rf_nx  = r1c[31:0];
				rs_nx  = r2c[31:0];
				sat_nx = r1c[32] | r2c[32];
			end
			default: begin
				rf_nx = '0;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			status_q      <= dv_side.status;
			root_first_q  <= rf_nx;
			root_second_q <= rs_nx;
			saturated_q   <= sat_nx;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign root_first  = root_first_q;
	assign root_second = root_second_q;
	assign saturated   = saturated_q;

	// flag results that must carry no root
	logic out_no_root, out_roots_zero;
	assign out_no_root    = status == qrs_pkg::ST_NONE || status == qrs_pkg::ST_DEGEN;
	assign out_roots_zero = root_first == 32'sd0 && root_second == 32'sd0 && !saturated;

	`QRS_ASSERT_IMP(a_noroot_zero, out_valid && out_no_root, out_roots_zero)
	`QRS_ASSERT_IMP(a_second_zero, out_valid && status != qrs_pkg::ST_TWO, root_second == 32'sd0)
	`QRS_ASSERT_NXT(a_accept_load, in_valid && in_ready, v_s1)
endmodule
`default_nettype wire

// File: rtl/core/qrs_sqrt_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt_pipe (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_vld,
	input  wire logic [qrs_pkg::RAD_W-1:0]     in_rad,
	input  wire qrs_pkg::sq_side_t             in_side,
	output logic                               out_vld,
	output logic [qrs_pkg::ROOT_W-1:0]         out_root,
	output qrs_pkg::sq_side_t                  out_side
);
	localparam int N = qrs_pkg::SQ_STAGES;

	logic                          vld  [0:N];
	logic [qrs_pkg::RAD_W-1:0]     rad  [0:N];
	logic [qrs_pkg::REM_W-1:0]     rem  [0:N];
	logic [qrs_pkg::ROOT_W-1:0]    root [0:N];
	qrs_pkg::sq_side_t             side [0:N];

	// feed the first digit step
	always_comb begin
		vld[0]  = in_vld;
		rad[0]  = in_rad;
		rem[0]  = '0;
		root[0] = '0;
		side[0] = in_side;
	end

	// one root bit per stage
	for (genvar k = 0; k < N; k++) begin : g_stg
		logic [qrs_pkg::REM_W+1:0] cur;
		logic [qrs_pkg::REM_W+1:0] trial;
		logic                      take;

		always_comb begin
			cur   = {rem[k], rad[k][qrs_pkg::RAD_W-1 -: 2]};
			trial = {2'b00, root[k], 2'b01};
			take  = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem[k+1]  <= take ? qrs_pkg::REM_W'(cur - trial) : qrs_pkg::REM_W'(cur);
				root[k+1] <= {root[k][qrs_pkg::ROOT_W-2:0], take};
				rad[k+1]  <= {rad[k][qrs_pkg::RAD_W-3:0], 2'b00};
				side[k+1] <= side[k];
			end
		end
	end

	assign out_vld  = vld[N];
	assign out_root = root[N];
	assign out_side = side[N];
endmodule
`default_nettype wire

// File: rtl/core/qrs_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
module qrs_div_pipe (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_vld,
	input  wire logic [qrs_pkg::NUM_W-1:0]   in_x1,
	input  wire logic [qrs_pkg::NUM_W-1:0]   in_x2,
	input  wire logic [qrs_pkg::DEN_W-1:0]   in_d,
	input  wire qrs_pkg::div_side_t          in_side,
	output logic                             out_vld,
	output logic [qrs_pkg::NUM_W-1:0]        out_q1,
	output logic [qrs_pkg::NUM_W-1:0]        out_q2,
	output qrs_pkg::div_side_t               out_side
);
	localparam int N = qrs_pkg::DIV_STAGES;

	logic                          vld  [0:N];
	logic [qrs_pkg::NUM_W-1:0]     x1   [0:N];
	logic [qrs_pkg::NUM_W-1:0]     x2   [0:N];
	logic [qrs_pkg::DEN_W-1:0]     r1   [0:N];
	logic [qrs_pkg::DEN_W-1:0]     r2   [0:N];
	logic [qrs_pkg::DEN_W-1:0]     dv   [0:N];
	qrs_pkg::div_side_t            side [0:N];

	// feed the first quotient step
	always_comb begin
		vld[0]  = in_vld;
		x1[0]   = in_x1;
		x2[0]   = in_x2;
		r1[0]   = '0;
		r2[0]   = '0;
		dv[0]   = in_d;
		side[0] = in_side;
	end

	// one quotient bit per stage for both lanes; quotient shifts in below the dividend
	for (genvar k = 0; k < N; k++) begin : g_stg
		logic [qrs_pkg::DEN_W:0] cur1;
		logic [qrs_pkg::DEN_W:0] cur2;
		logic [qrs_pkg::DEN_W:0] dext;
		logic                    take1;
		logic                    take2;

		always_comb begin
			cur1  = {r1[k], x1[k][qrs_pkg::NUM_W-1]};
			cur2  = {r2[k], x2[k][qrs_pkg::NUM_W-1]};
			dext  = {1'b0, dv[k]};
			take1 = (cur1 >= dext);
			take2 = (cur2 >= dext);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k+1] <= 1'b0;
			end else if (en) begin
				vld[k+1] <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r1[k+1]   <= take1 ? qrs_pkg::DEN_W'(cur1 - dext) : qrs_pkg::DEN_W'(cur1);
				r2[k+1]   <= take2 ? qrs_pkg::DEN_W'(cur2 - dext) : qrs_pkg::DEN_W'(cur2);
				x1[k+1]   <= {x1[k][qrs_pkg::NUM_W-2:0], take1};
				x2[k+1]   <= {x2[k][qrs_pkg::NUM_W-2:0], take2};
				dv[k+1]   <= dv[k];
				side[k+1] <= side[k];
			end
		end
	end

	assign out_vld  = vld[N];
	assign out_q1   = x1[N];
	assign out_q2   = x2[N];
	assign out_side = side[N];
endmodule
`default_nettype wire
